// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define QB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define QB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/qbsdc_pkg.sv =====
// ---------------------------------------------------------------------------
// qbsdc_pkg
// Types and constants for the bus slave data cycle block.
// ---------------------------------------------------------------------------
package qbsdc_pkg;

    localparam int DAL_W       = 23;
    localparam int DATA_W      = 16;
    localparam int PHASE_W     = 3;
    localparam int KIND_W      = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 64;

    // Cycle phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT       = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DIN_DONE   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DOUT_DONE  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DIN_BLOCK  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DOUT_BLOCK = 3'd5;

    // Backend access kinds
    localparam logic [KIND_W-1:0] KIND_READ       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BYTE_WRITE = 2'd2;

    // One bus sample; last member sits in bit 0
    typedef struct packed {
        logic              event_acked;
        logic [DATA_W-1:0] read_data;
        logic              backend_ok;
        logic [DAL_W-1:0]  dal_lines;
        logic              bus_init;
        logic              write_byte;
        logic              reply_seen;
        logic              dout;
        logic              din;
        logic              sync_live;
        logic              sync_latched;
    } t_in_item;

    // Bus-facing control state (address kept apart, its width is a parameter)
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               reply_on;
        logic               ref_on;
        logic               dal_driven;
        logic [DATA_W-1:0]  dal_data;
    } t_ctl_state;

    typedef struct packed {
        logic               access_valid;
        logic [KIND_W-1:0]  access_kind;
        logic [DAL_W-1:0]   access_address;
        logic [DATA_W-1:0]  write_value;
        logic [DATA_W-1:0]  dal_out;
        logic               dal_drive;
        logic               reply_out;
        logic               ref_out;
        logic               release_dal_latch;
        logic [PHASE_W-1:0] phase;
    } t_result;

endpackage

// ===== hdl/qbsdc_step.sv =====
// ---------------------------------------------------------------------------
// qbsdc_step
// One bus sample against the current cycle state: next state and result.
// ---------------------------------------------------------------------------
module qbsdc_step #(
    parameter int ADDR_BITS = 23
) (
    input  qbsdc_pkg::t_in_item    i_item,
    input  qbsdc_pkg::t_ctl_state  i_st,
    input  logic [ADDR_BITS-1:0]   i_addr,
    output qbsdc_pkg::t_ctl_state  o_st,
    output logic [ADDR_BITS-1:0]   o_addr,
    output qbsdc_pkg::t_result     o_res
);

    always_comb begin
        o_st  = i_st;
        o_addr = i_addr;
        o_res = '0;
        case (i_st.phase)
            qbsdc_pkg::PH_IDLE: begin
                if (i_item.sync_latched) begin
                    o_addr       = i_item.dal_lines[ADDR_BITS-1:0];
                    o_st.phase   = qbsdc_pkg::PH_WAIT;
                end
            end
            qbsdc_pkg::PH_WAIT: begin
                if (!i_item.sync_live || i_item.reply_seen || i_item.bus_init) begin
                    o_st.phase      = qbsdc_pkg::PH_IDLE;
                    o_st.reply_on   = 1'b0;
                    o_st.ref_on     = 1'b0;
                    o_st.dal_driven = 1'b0;
                end else if (i_item.din) begin
                    o_res.access_valid   = 1'b1;
                    o_res.access_kind    = qbsdc_pkg::KIND_READ;
                    o_res.access_address = qbsdc_pkg::DAL_W'(i_addr);
                    if (!i_item.backend_ok) begin
                        o_st.phase      = qbsdc_pkg::PH_IDLE;
                        o_st.reply_on   = 1'b0;
                        o_st.ref_on     = 1'b0;
                        o_st.dal_driven = 1'b0;
                    end else begin
                        o_st.dal_data   = i_item.read_data;
                        o_st.dal_driven = 1'b1;
                        o_st.reply_on   = 1'b1;
                        o_st.ref_on     = 1'b1;
                        o_st.phase      = qbsdc_pkg::PH_DIN_DONE;
                    end
                end else if (i_item.dout) begin
                    o_res.release_dal_latch = 1'b1;
                    o_res.access_valid      = 1'b1;
                    o_res.access_address    = qbsdc_pkg::DAL_W'(i_addr);
                    if (i_item.write_byte) begin
                        o_res.access_kind = qbsdc_pkg::KIND_BYTE_WRITE;
                        // odd address takes the upper byte lane
                        o_res.write_value = i_addr[0]
                            ? qbsdc_pkg::DATA_W'(i_item.dal_lines[15:8])
                            : qbsdc_pkg::DATA_W'(i_item.dal_lines[7:0]);
                    end else begin
                        o_res.access_kind = qbsdc_pkg::KIND_WRITE;
                        o_res.write_value = i_item.dal_lines[qbsdc_pkg::DATA_W-1:0];
                    end
                    if (!i_item.backend_ok) begin
                        o_st.phase      = qbsdc_pkg::PH_IDLE;
                        o_st.reply_on   = 1'b0;
                        o_st.ref_on     = 1'b0;
                        o_st.dal_driven = 1'b0;
                    end else begin
                        o_st.reply_on = 1'b1;
                        o_st.ref_on   = 1'b1;
                        o_st.phase    = qbsdc_pkg::PH_DOUT_DONE;
                    end
                end
            end
            qbsdc_pkg::PH_DIN_DONE: begin
                if (!i_item.din && i_item.event_acked) begin
                    o_st.reply_on   = 1'b0;
                    o_st.ref_on     = 1'b0;
                    o_st.dal_driven = 1'b0;
                    o_st.phase      = qbsdc_pkg::PH_DIN_BLOCK;
                end
            end
            qbsdc_pkg::PH_DOUT_DONE: begin
                if (!i_item.dout && i_item.event_acked) begin
                    o_st.reply_on = 1'b0;
                    o_st.ref_on   = 1'b0;
                    o_st.phase    = qbsdc_pkg::PH_DOUT_BLOCK;
                end
            end
            qbsdc_pkg::PH_DIN_BLOCK: begin
                if (!i_item.sync_live || i_item.bus_init) begin
                    o_st.phase      = qbsdc_pkg::PH_IDLE;
                    o_st.reply_on   = 1'b0;
                    o_st.ref_on     = 1'b0;
                    o_st.dal_driven = 1'b0;
                end else if (i_item.dout) begin
                    // read-modify-write: same address
                    o_st.phase = qbsdc_pkg::PH_WAIT;
                end else if (i_item.din) begin
                    o_addr     = i_addr + ADDR_BITS'(2);
                    o_st.phase = qbsdc_pkg::PH_WAIT;
                end
            end
            qbsdc_pkg::PH_DOUT_BLOCK: begin
                if (!i_item.sync_live || i_item.bus_init) begin
                    o_st.phase      = qbsdc_pkg::PH_IDLE;
                    o_st.reply_on   = 1'b0;
                    o_st.ref_on     = 1'b0;
                    o_st.dal_driven = 1'b0;
                end else if (i_item.dout) begin
                    o_addr     = i_addr + ADDR_BITS'(2);
                    o_st.phase = qbsdc_pkg::PH_WAIT;
                end
            end
            default: begin
                o_st.phase      = qbsdc_pkg::PH_IDLE;
                o_st.reply_on   = 1'b0;
                o_st.ref_on     = 1'b0;
                o_st.dal_driven = 1'b0;
            end
        endcase
        o_res.dal_drive = o_st.dal_driven;
        o_res.dal_out   = o_st.dal_driven ? o_st.dal_data : '0;
        o_res.reply_out = o_st.reply_on;
        o_res.ref_out   = o_st.ref_on;
        o_res.phase     = o_st.phase;
    end

endmodule

// ===== hdl/qbus_slave_data_cycle_top.sv =====
// ---------------------------------------------------------------------------
// qbus_slave_data_cycle_top
// Slave side of a multiplexed address/data bus data cycle, one result per sample.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+-------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | 48-bit bus sample
//  m_axis   | out | m_axis_tvalid / m_axis_tready | 64-bit result, kind in tuser
//
//  One transaction per clock sustained while m_axis_tready stays high; each
//  sample passes the input register, then the result register.
//  The phase logic is a single pass between the input and result registers.
//  Reset (i_rst_n low, synchronous) empties both registers and returns the
//  cycle state to idle with RPLY, REF and the DAL drive off.
//  A stalled result holds the result register and, behind it, the input
//  register; the state advances only when a sample moves into the result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qbus_slave_data_cycle_top #(
    parameter int ADDR_BITS = 23    // latched address width, 17 to 23
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] sync_latched, [1] sync_live, [2] din, [3] dout, [4] reply_seen,
    // [5] write_byte, [6] bus_init, [29:7] dal_lines, [30] backend_ok,
    // [46:31] read_data, [47] event_acked
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] access_valid, [23:1] access_address, [39:24] write_value,
    // [55:40] dal_out, [56] dal_drive, [57] reply_out, [58] ref_out,
    // [59] release_dal_latch, [62:60] phase, [63] zero
    output logic [63:0] m_axis_tdata,
    // [1:0] access_kind
    output logic [1:0]  m_axis_tuser
);

    logic                   r_in_valid;
    qbsdc_pkg::t_in_item    r_in;
    logic                   r_out_valid;
    qbsdc_pkg::t_result     r_res;
    qbsdc_pkg::t_ctl_state  r_st;
    logic [ADDR_BITS-1:0]   r_addr;

    qbsdc_pkg::t_ctl_state  n_st;
    logic [ADDR_BITS-1:0]   n_addr;
    qbsdc_pkg::t_result     n_res;

    logic                   w_fire;

    // Move the held sample into the result whenever the result slot frees up
    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;

    qbsdc_step #(
        .ADDR_BITS (ADDR_BITS)
    ) u_step (
        .i_item (r_in),
        .i_st   (r_st),
        .i_addr (r_addr),
        .o_st   (n_st),
        .o_addr (n_addr),
        .o_res  (n_res)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_st.phase       <= qbsdc_pkg::PH_IDLE;
            r_st.reply_on    <= 1'b0;
            r_st.ref_on      <= 1'b0;
            r_st.dal_driven  <= 1'b0;
            r_st.dal_data    <= '0;
            r_addr           <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_st        <= n_st;
                r_addr      <= n_addr;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= qbsdc_pkg::t_in_item'(s_axis_tdata);
        end
        if (w_fire) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_res.access_kind;
    assign m_axis_tdata  = {1'b0,
                            r_res.phase,
                            r_res.release_dal_latch,
                            r_res.ref_out,
                            r_res.reply_out,
                            r_res.dal_drive,
                            r_res.dal_out,
                            r_res.write_value,
                            r_res.access_address,
                            r_res.access_valid};

    // Idle cycle state never leaves the bus driven
    `QB_ASSERT_NOW(a_idle_quiet, r_st.phase == qbsdc_pkg::PH_IDLE, !r_st.reply_on && !r_st.ref_on && !r_st.dal_driven, "idle phase with bus lines driven")
    // No access means empty access fields
    `QB_ASSERT_NOW(a_no_access_zero, r_out_valid && !r_res.access_valid, r_res.access_kind == qbsdc_pkg::KIND_READ && r_res.access_address == '0 && r_res.write_value == '0, "access fields set without access")
    // Latch release only comes with a write access
    `QB_ASSERT_NOW(a_release_write, r_out_valid && r_res.release_dal_latch, r_res.access_valid && (r_res.access_kind == qbsdc_pkg::KIND_WRITE || r_res.access_kind == qbsdc_pkg::KIND_BYTE_WRITE), "latch release without write")
    // Undriven data lines read as zero
    `QB_ASSERT_NOW(a_dal_zero, r_out_valid && !r_res.dal_drive, r_res.dal_out == '0, "dal_out set while not driven")
    // State moves only with a sample passing into the result
    `QB_ASSERT_NEXT(a_state_hold, !w_fire, $stable(r_st) && $stable(r_addr), "cycle state changed without a sample")

endmodule
